// ===== rtl/ocpe_pkg.sv =====
// Package for the OFDM pilot channel estimator: sizes, register indexes,
// result type and the Q16.16 saturation helper. No dependencies.
package ocpe_pkg;

	localparam int MAX_SUBCARRIERS = 1024;
	localparam int MAX_SLOTS       = 16;

	localparam int SC_W    = $clog2(MAX_SUBCARRIERS);
	localparam int N_W     = $clog2(MAX_SUBCARRIERS + 1);
	localparam int SLOT_W  = $clog2(MAX_SLOTS + 1);
	localparam int FLAG_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int KT_DEPTH = MAX_SLOTS * MAX_SUBCARRIERS;
	localparam int KT_AW    = $clog2(KT_DEPTH);
	localparam int EST_W    = 128;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RX_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KN_THR = 2'd2;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;

	localparam logic [10:0] ACTIVE_RESET = 11'd64;
	localparam logic [31:0] RX_THR_RESET = 32'd107374;
	localparam logic [31:0] KN_THR_RESET = 32'd0;
	localparam logic [31:0] ONE_Q16      = 32'h0001_0000;

	localparam int DIVIDEND_W = 49;
	localparam int DIVISOR_W  = 33;

	typedef struct packed {
		logic [31:0] ci;
		logic [31:0] cr;
		logic [31:0] ii;
		logic [31:0] ir;
	} est_t;

	// Saturate an unsigned quotient magnitude to signed Q16.16 with sign
	function automatic logic [31:0] sat_q16(input logic [DIVIDEND_W-1:0] q, input logic neg);
		logic [31:0] r;
		if (!neg) begin
			r = (q > DIVIDEND_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
		end else begin
			r = (q > DIVIDEND_W'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q[31:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/ocpe_if.sv =====
// Channel interfaces of the OFDM pilot channel estimator: sample input,
// estimate output and register write. Depends on ocpe_pkg.
interface ocpe_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic        frame_start;
	logic signed [15:0] sample_re;
	logic signed [15:0] sample_im;
	logic [3:0]  slot_index;
	logic [9:0]  load_subcarrier;
	logic signed [15:0] known_re;
	logic signed [15:0] known_im;
	logic        pilot_flag;
	modport source (output valid, mode, frame_start, sample_re, sample_im, slot_index,
		load_subcarrier, known_re, known_im, pilot_flag, input ready);
	modport sink (input valid, mode, frame_start, sample_re, sample_im, slot_index,
		load_subcarrier, known_re, known_im, pilot_flag, output ready);
endinterface

interface ocpe_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] inv_re;
	logic signed [31:0] inv_im;
	logic signed [31:0] ctf_re;
	logic signed [31:0] ctf_im;
	logic        last_subcarrier;
	modport source (output valid, inv_re, inv_im, ctf_re, ctf_im, last_subcarrier,
		input ready);
	modport sink (input valid, inv_re, inv_im, ctf_re, ctf_im, last_subcarrier,
		output ready);
endinterface

interface ocpe_cfg_if;
	logic        valid;
	logic        ready;
	logic [ocpe_pkg::CFG_IDX_W-1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ofdm_pilot_channel_estimator.sv =====
// OFDM pilot channel estimator: usage notes below.
// Depends on ocpe_pkg, ocpe_if, ocpe_ram and ocpe_div.
//
// Channels: in_ch takes subcarrier samples (mode 0) and known-symbol loads
// (mode 1); out_ch gives one estimate per sample, none per load; cfg_ch
// writes active_subcarriers, received_power_threshold, known_power_threshold.
// cfg_ch is always ready; write it only while the block is idle.
// Known-symbol entries sit in a 16K x 32 RAM, stored estimates in a
// 1024 x 128 RAM, each read once per sample through a registered read port.
// Per sample: a load is written from the idle state; a sample on a slot
// that is not known passes through the read and finish states; a sample
// on a known slot with usable power adds the sum state and four divisions
// (start, 49 quotient bits, hand-off) on one shared divider; weak power
// skips the divisions. One item is in flight at a time.
// After reset a clearing pass sets all 1024 stored estimates to 1+0j;
// in_ch is not ready during it.
// If the receiver stalls, the finished estimate waits in the output register;
// the next item is still taken but waits in ST_FIN until that transfer completes.
module ofdm_pilot_channel_estimator (
	input  logic clk,
	input  logic arst_n,
	ocpe_in_if.sink    in_ch,
	ocpe_out_if.source out_ch,
	ocpe_cfg_if.sink   cfg_ch
);
	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_SUM, ST_DIV, ST_FIN} state_t;

	localparam int SC_W = ocpe_pkg::SC_W;
	localparam int N_W  = ocpe_pkg::N_W;
	localparam int SL_W = ocpe_pkg::SLOT_W;

	state_t state_q;
	logic [SC_W-1:0] clr_q;

	logic [10:0] act_q;
	logic [31:0] rthr_q;
	logic [31:0] kthr_q;

	logic [ocpe_pkg::MAX_SLOTS-1:0] known_q;
	logic [ocpe_pkg::MAX_SLOTS-1:0] pilot_q;
	logic [SL_W-1:0] tlen_q;
	logic [SL_W-1:0] slot_q;
	logic [SC_W-1:0] sc_q;

	logic signed [15:0] a_s1, b_s1;
	logic [SC_W-1:0] sc_s1;
	logic last_s1, known_s1, pilot_s1;

	logic signed [31:0] pca_s2, pdb_s2, pda_s2, pcb_s2, paa_s2, pbb_s2, pcc_s2, pdd_s2;
	logic signed [32:0] n0_s3, n1_s3;
	logic [31:0] rmag_s3, kmag_s3;

	logic [1:0] idx_q;
	logic dpend_q;
	logic neg_q;
	ocpe_pkg::est_t res_q;

	logic out_valid_q;
	ocpe_pkg::est_t out_q;
	logic out_last_q;

	// RAM ports
	logic kt_we, kt_re;
	logic [ocpe_pkg::KT_AW-1:0] kt_waddr, kt_raddr;
	logic [31:0] kt_wdata, kt_rdata;
	logic est_we, est_re;
	logic [SC_W-1:0] est_waddr, est_raddr;
	logic [ocpe_pkg::EST_W-1:0] est_wdata, est_rdata;

	// Divider
	logic div_start, div_busy, div_done;
	logic [ocpe_pkg::DIVIDEND_W-1:0] div_dividend, div_quo;
	logic [ocpe_pkg::DIVISOR_W-1:0] div_divisor;
	logic signed [32:0] sel_num;
	logic [31:0] sel_den;
	logic [32:0] sel_mag;

	// Accept-side decode
	logic accept, is_load, load_ok, fin_go;
	logic [N_W-1:0] n_eff;
	logic [SC_W-1:0] sc_cur;
	logic [SL_W-1:0] slot_eff;
	logic slot_known, slot_pilot, last_cur;
	logic [SL_W-1:0] load_slot_p1;
	logic signed [15:0] kc, kd;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign accept  = in_ch.valid && in_ch.ready;
	assign is_load = (in_ch.mode == ocpe_pkg::MODE_LOAD);
	assign load_ok = (32'(in_ch.slot_index) < 32'(ocpe_pkg::MAX_SLOTS))
	              && (32'(in_ch.load_subcarrier) < 32'(ocpe_pkg::MAX_SUBCARRIERS));
	assign load_slot_p1 = SL_W'(in_ch.slot_index) + SL_W'(1);

	always_comb begin
		if (act_q == 11'd0) begin
			n_eff = N_W'(1);
		end else if (32'(act_q) > 32'(ocpe_pkg::MAX_SUBCARRIERS)) begin
			n_eff = N_W'(ocpe_pkg::MAX_SUBCARRIERS);
		end else begin
			n_eff = N_W'(act_q);
		end
		sc_cur     = sc_q;
		slot_eff   = (sc_cur == '0 && in_ch.frame_start) ? '0 : slot_q;
		slot_known = (32'(slot_eff) < 32'(ocpe_pkg::MAX_SLOTS))
		          && known_q[slot_eff[ocpe_pkg::FLAG_AW-1:0]];
		slot_pilot = pilot_q[slot_eff[ocpe_pkg::FLAG_AW-1:0]];
		last_cur   = (N_W'(sc_cur) + N_W'(1)) >= n_eff;
	end

	// Known-symbol table: imaginary part in the upper half
	assign kt_we    = accept && is_load && load_ok;
	assign kt_waddr = ocpe_pkg::KT_AW'(32'(in_ch.slot_index) * ocpe_pkg::MAX_SUBCARRIERS
	                  + 32'(in_ch.load_subcarrier));
	assign kt_wdata = {in_ch.known_im, in_ch.known_re};
	assign kt_re    = accept && !is_load;
	assign kt_raddr = ocpe_pkg::KT_AW'(32'(slot_eff[ocpe_pkg::FLAG_AW-1:0])
	                  * ocpe_pkg::MAX_SUBCARRIERS + 32'(sc_cur));

	ocpe_ram #(.WIDTH(32), .DEPTH(ocpe_pkg::KT_DEPTH)) u_known_ram (
		.clk(clk), .we(kt_we), .waddr(kt_waddr), .wdata(kt_wdata),
		.re(kt_re), .raddr(kt_raddr), .rdata(kt_rdata)
	);

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			est_we    = 1'b1;
			est_waddr = clr_q;
			est_wdata = {32'd0, ocpe_pkg::ONE_Q16, 32'd0, ocpe_pkg::ONE_Q16};
		end else begin
			est_we    = fin_go && known_s1 && pilot_s1;
			est_waddr = sc_s1;
			est_wdata = res_q;
		end
	end
	assign est_re    = accept && !is_load;
	assign est_raddr = sc_cur;

	ocpe_ram #(.WIDTH(ocpe_pkg::EST_W), .DEPTH(ocpe_pkg::MAX_SUBCARRIERS)) u_est_ram (
		.clk(clk), .we(est_we), .waddr(est_waddr), .wdata(est_wdata),
		.re(est_re), .raddr(est_raddr), .rdata(est_rdata)
	);

	// Division operands: inverse parts over received power, transfer over known
	always_comb begin
		unique case (idx_q)
			2'd0:    sel_num = n0_s3;
			2'd1:    sel_num = n1_s3;
			2'd2:    sel_num = n0_s3;
			default: sel_num = -n1_s3;
		endcase
		sel_den      = idx_q[1] ? kmag_s3 : rmag_s3;
		sel_mag      = sel_num[32] ? 33'(-sel_num) : 33'(sel_num);
		div_dividend = {sel_mag[31:0], 17'd0} + ocpe_pkg::DIVIDEND_W'(sel_den);
		div_divisor  = {sel_den, 1'b0};
	end
	assign div_start = (state_q == ST_DIV) && !dpend_q;

	ocpe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .busy(div_busy), .done(div_done), .quotient(div_quo)
	);

	assign kc = kt_rdata[15:0];
	assign kd = kt_rdata[31:16];

	// Control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			act_q       <= ocpe_pkg::ACTIVE_RESET;
			rthr_q      <= ocpe_pkg::RX_THR_RESET;
			kthr_q      <= ocpe_pkg::KN_THR_RESET;
			known_q     <= '0;
			pilot_q     <= '0;
			tlen_q      <= '0;
			slot_q      <= '0;
			sc_q        <= '0;
			idx_q       <= '0;
			dpend_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					ocpe_pkg::CFG_ACTIVE: act_q  <= cfg_ch.data[10:0];
					ocpe_pkg::CFG_RX_THR: rthr_q <= cfg_ch.data;
					ocpe_pkg::CFG_KN_THR: kthr_q <= cfg_ch.data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == ocpe_pkg::MAX_SUBCARRIERS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_load) begin
						if (load_ok) begin
							known_q[in_ch.slot_index[ocpe_pkg::FLAG_AW-1:0]] <= 1'b1;
							pilot_q[in_ch.slot_index[ocpe_pkg::FLAG_AW-1:0]] <= in_ch.pilot_flag;
							tlen_q <= (tlen_q < load_slot_p1) ? load_slot_p1 : tlen_q;
							slot_q <= (tlen_q < load_slot_p1) ? load_slot_p1 : tlen_q;
							sc_q   <= '0;
						end
					end else if (accept) begin
						if (last_cur) begin
							sc_q   <= '0;
							slot_q <= (32'(slot_eff) < 32'(ocpe_pkg::MAX_SLOTS))
							          ? slot_eff + 1'b1 : slot_eff;
						end else begin
							sc_q   <= sc_cur + 1'b1;
							slot_q <= slot_eff;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= known_s1 ? ST_SUM : ST_FIN;
				end
				ST_SUM: begin
					idx_q   <= '0;
					state_q <= ((32'(paa_s2) + 32'(pbb_s2)) > rthr_q
					           && (32'(pcc_s2) + 32'(pdd_s2)) > kthr_q) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_start) begin
						dpend_q <= 1'b1;
					end
					if (div_done) begin
						dpend_q <= 1'b0;
						idx_q   <= idx_q + 1'b1;
						if (idx_q == 2'd3) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (accept && !is_load) begin
			a_s1     <= in_ch.sample_re;
			b_s1     <= in_ch.sample_im;
			sc_s1    <= sc_cur;
			last_s1  <= last_cur;
			known_s1 <= slot_known;
			pilot_s1 <= slot_pilot;
		end
		if (state_q == ST_READ) begin
			pca_s2 <= kc * a_s1;
			pdb_s2 <= kd * b_s1;
			pda_s2 <= kd * a_s1;
			pcb_s2 <= kc * b_s1;
			paa_s2 <= a_s1 * a_s1;
			pbb_s2 <= b_s1 * b_s1;
			pcc_s2 <= kc * kc;
			pdd_s2 <= kd * kd;
			// Stored estimates go out as they are on slots that are not known
			res_q  <= est_rdata;
		end
		if (state_q == ST_SUM) begin
			n0_s3   <= 33'(pca_s2) + 33'(pdb_s2);
			n1_s3   <= 33'(pda_s2) - 33'(pcb_s2);
			rmag_s3 <= 32'(paa_s2) + 32'(pbb_s2);
			kmag_s3 <= 32'(pcc_s2) + 32'(pdd_s2);
			res_q   <= '0;
		end
		if (div_start) begin
			neg_q <= sel_num[32];
		end
		if (state_q == ST_DIV && div_done) begin
			unique case (idx_q)
				2'd0:    res_q.ir <= ocpe_pkg::sat_q16(div_quo, neg_q);
				2'd1:    res_q.ii <= ocpe_pkg::sat_q16(div_quo, neg_q);
				2'd2:    res_q.cr <= ocpe_pkg::sat_q16(div_quo, neg_q);
				default: res_q.ci <= ocpe_pkg::sat_q16(div_quo, neg_q);
			endcase
		end
		if (fin_go) begin
			out_q      <= res_q;
			out_last_q <= last_s1;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.inv_re          = out_q.ir;
	assign out_ch.inv_im          = out_q.ii;
	assign out_ch.ctf_re          = out_q.cr;
	assign out_ch.ctf_im          = out_q.ci;
	assign out_ch.last_subcarrier = out_last_q;

`ifndef SYNTH
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_est_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		est_we |-> (state_q == ST_CLEAR) || (state_q == ST_FIN && known_s1 && pilot_s1))
		else $error("estimate RAM written outside clear or pilot write-back");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result presented without finishing an item");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(tlen_q) <= ocpe_pkg::MAX_SLOTS) && (32'(slot_q) <= ocpe_pkg::MAX_SLOTS))
		else $error("slot counter beyond slot count");
`endif
endmodule

// ===== rtl/ocpe_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ocpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/ocpe_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ocpe_pkg for operand widths.
module ocpe_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ocpe_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [ocpe_pkg::DIVISOR_W-1:0]     divisor,
	output logic                               busy,
	output logic                               done,
	output logic [ocpe_pkg::DIVIDEND_W-1:0]    quotient
);
	localparam int CNT_W = $clog2(ocpe_pkg::DIVIDEND_W + 1);

	logic [CNT_W-1:0]                    cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic [ocpe_pkg::DIVISOR_W-1:0]      rem_q;
	logic [ocpe_pkg::DIVISOR_W-1:0]      div_q;
	logic [ocpe_pkg::DIVIDEND_W-1:0]     quo_q;
	logic [ocpe_pkg::DIVISOR_W:0]        rem_sh;
	logic                                fits;

	assign rem_sh = {rem_q, quo_q[ocpe_pkg::DIVIDEND_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ocpe_pkg::DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? ocpe_pkg::DIVISOR_W'(rem_sh - {1'b0, div_q})
			              : rem_sh[ocpe_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[ocpe_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule
